// ===== rtl/hsv2rgb_pkg.sv =====
// Shared types and constants for the HSV to RGB colour converter.
// Holds the word formats of both channels and of the internal pipeline stages.
// Depends on nothing.
package hsv2rgb_pkg;

    localparam int HUE_BITS     = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int SCALE_BITS   = HUE_BITS + CHANNEL_BITS;
    localparam int PROD_BITS    = 2 * CHANNEL_BITS;

    localparam logic [CHANNEL_BITS-1:0] CH_MAX     = '1;
    localparam logic [SCALE_BITS-1:0]   FULL_SCALE = {CH_MAX, {HUE_BITS{1'b0}}};

    typedef enum logic [2:0] {
        SECTOR_RED     = 3'd0,
        SECTOR_YELLOW  = 3'd1,
        SECTOR_GREEN   = 3'd2,
        SECTOR_CYAN    = 3'd3,
        SECTOR_BLUE    = 3'd4,
        SECTOR_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_word_t;

    typedef struct packed {
        sector_t                 sector;
        logic [HUE_BITS-1:0]     frac;
        logic [CHANNEL_BITS-1:0] sat;
        logic [CHANNEL_BITS-1:0] val;
    } sector_word_t;

    typedef struct packed {
        sector_t                 sector;
        logic [CHANNEL_BITS-1:0] val;
        logic [PROD_BITS-1:0]    p_prod;
        logic [SCALE_BITS-1:0]   sf;
        logic [SCALE_BITS-1:0]   sg;
    } product_word_t;

    typedef struct packed {
        sector_t                 sector;
        logic [CHANNEL_BITS-1:0] val;
        logic [PROD_BITS-1:0]    p_prod;
        logic [PROD_BITS-1:0]    q_prod;
        logic [PROD_BITS-1:0]    t_prod;
    } scaled_word_t;

endpackage

// ===== rtl/hsv2rgb_sector.sv =====
// First pipeline stage: splits the hue into a sector and a fraction within it.
// Depends on hsv2rgb_pkg.
module hsv2rgb_sector (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hsv2rgb_pkg::hsv_word_t    in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsv2rgb_pkg::sector_word_t out_data
);

    logic                                   valid_reg;
    hsv2rgb_pkg::sector_word_t              data_reg;
    hsv2rgb_pkg::sector_word_t              data_next;
    logic [hsv2rgb_pkg::HUE_BITS+2:0]       hue6;
    logic                                   load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        hue6 = ({3'b000, in_data.hue} << 2) + ({3'b000, in_data.hue} << 1);
        data_next.sector = hsv2rgb_pkg::sector_t'(hue6[hsv2rgb_pkg::HUE_BITS+2:
                                                       hsv2rgb_pkg::HUE_BITS]);
        data_next.frac   = hue6[hsv2rgb_pkg::HUE_BITS-1:0];
        data_next.sat    = in_data.saturation;
        data_next.val    = in_data.brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/hsv2rgb_scale.sv =====
// Second and third pipeline stages: saturation products, then the products with value.
// Depends on hsv2rgb_pkg.
module hsv2rgb_scale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hsv2rgb_pkg::sector_word_t in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsv2rgb_pkg::scaled_word_t out_data
);

    localparam int WIDE_BITS = hsv2rgb_pkg::CHANNEL_BITS + hsv2rgb_pkg::SCALE_BITS;

    logic                                s2_valid_reg;
    hsv2rgb_pkg::product_word_t          s2_reg;
    hsv2rgb_pkg::product_word_t          s2_next;
    logic                                s2_ready;
    logic                                s3_valid_reg;
    hsv2rgb_pkg::scaled_word_t           s3_reg;
    hsv2rgb_pkg::scaled_word_t           s3_next;
    logic                                s3_ready;
    logic [hsv2rgb_pkg::HUE_BITS:0]      cfrac;
    logic [hsv2rgb_pkg::SCALE_BITS-1:0]  nq;
    logic [hsv2rgb_pkg::SCALE_BITS-1:0]  nt;
    logic [WIDE_BITS-1:0]                q_full;
    logic [WIDE_BITS-1:0]                t_full;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;

    always_comb
    begin
        cfrac = {1'b1, {hsv2rgb_pkg::HUE_BITS{1'b0}}} - {1'b0, in_data.frac};
        s2_next.sector = in_data.sector;
        s2_next.val    = in_data.val;
        s2_next.p_prod = hsv2rgb_pkg::PROD_BITS'(in_data.val)
                       * hsv2rgb_pkg::PROD_BITS'(hsv2rgb_pkg::CH_MAX - in_data.sat);
        s2_next.sf     = hsv2rgb_pkg::SCALE_BITS'(in_data.sat)
                       * hsv2rgb_pkg::SCALE_BITS'(in_data.frac);
        s2_next.sg     = hsv2rgb_pkg::SCALE_BITS'(in_data.sat)
                       * hsv2rgb_pkg::SCALE_BITS'(cfrac);
    end

    always_comb
    begin
        nq     = hsv2rgb_pkg::FULL_SCALE - s2_reg.sf;
        nt     = hsv2rgb_pkg::FULL_SCALE - s2_reg.sg;
        q_full = WIDE_BITS'(s2_reg.val) * WIDE_BITS'(nq);
        t_full = WIDE_BITS'(s2_reg.val) * WIDE_BITS'(nt);
        s3_next.sector = s2_reg.sector;
        s3_next.val    = s2_reg.val;
        s3_next.p_prod = s2_reg.p_prod;
        s3_next.q_prod = q_full[WIDE_BITS-1:hsv2rgb_pkg::HUE_BITS];
        s3_next.t_prod = t_full[WIDE_BITS-1:hsv2rgb_pkg::HUE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s2_ready)
        begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(s2_reg))
    else $error("A stalled product word was lost or changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_reg.q_prod >= s3_reg.p_prod)
    else $error("The q product fell below the p product.");

endmodule

// ===== rtl/hsv2rgb_route.sv =====
// Last pipeline stage: scales the products back to channel range and routes them by sector.
// Depends on hsv2rgb_pkg.
module hsv2rgb_route (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hsv2rgb_pkg::scaled_word_t in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hsv2rgb_pkg::rgb_word_t    out_data
);

    localparam int CB = hsv2rgb_pkg::CHANNEL_BITS;

    logic                   valid_reg;
    hsv2rgb_pkg::rgb_word_t rgb_reg;
    hsv2rgb_pkg::rgb_word_t rgb_next;
    logic [CB-1:0]          p_ch;
    logic [CB-1:0]          q_ch;
    logic [CB-1:0]          t_ch;
    logic [CB-1:0]          v_ch;

    // Division by 2^n - 1 of a product no larger than the square of full scale.
    function automatic logic [CB-1:0] div_max(input logic [hsv2rgb_pkg::PROD_BITS-1:0] y);
        logic [CB:0] hi;
        logic [CB:0] sum;
        logic [CB:0] quo;
        hi  = {1'b0, y[2*CB-1:CB]};
        sum = hi + {1'b0, y[CB-1:0]};
        quo = hi + (CB+1)'(sum >= {1'b0, hsv2rgb_pkg::CH_MAX})
                 + (CB+1)'(sum >= {hsv2rgb_pkg::CH_MAX, 1'b0});
        return quo[CB-1:0];
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        v_ch = in_data.val;
        p_ch = div_max(in_data.p_prod);
        q_ch = div_max(in_data.q_prod);
        t_ch = div_max(in_data.t_prod);
        case (in_data.sector)
            hsv2rgb_pkg::SECTOR_RED:
            begin
                rgb_next = '{red: v_ch, green: t_ch, blue: p_ch};
            end
            hsv2rgb_pkg::SECTOR_YELLOW:
            begin
                rgb_next = '{red: q_ch, green: v_ch, blue: p_ch};
            end
            hsv2rgb_pkg::SECTOR_GREEN:
            begin
                rgb_next = '{red: p_ch, green: v_ch, blue: t_ch};
            end
            hsv2rgb_pkg::SECTOR_CYAN:
            begin
                rgb_next = '{red: p_ch, green: q_ch, blue: v_ch};
            end
            hsv2rgb_pkg::SECTOR_BLUE:
            begin
                rgb_next = '{red: t_ch, green: p_ch, blue: v_ch};
            end
            default:
            begin
                rgb_next = '{red: v_ch, green: p_ch, blue: q_ch};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = rgb_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> rgb_next.red <= v_ch && rgb_next.green <= v_ch && rgb_next.blue <= v_ch)
    else $error("A channel exceeds the brightness of its pixel.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> rgb_next.red == v_ch || rgb_next.green == v_ch || rgb_next.blue == v_ch)
    else $error("No channel carries the brightness of its pixel.");

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB colour converter, top level; instantiates the sector, scale and route
// stages and takes its word formats from hsv2rgb_pkg. A pixel word (16-bit hue as a
// fraction of a full turn, 8-bit saturation and brightness) enters on the hsv channel
// and its red, green and blue word leaves on the rgb channel after the four register
// stages (sector, two in scale, route), two of which hold the saturation and brightness
// multipliers. The pipeline takes a new word in every cycle while rgb is not stalled, so
// the sustained rate is one pixel per clock. Back-pressure on rgb stalls only the stages
// that are full, and nothing is dropped or repeated. Results are truncated toward zero.
module hsv_to_rgb_converter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hsv_valid,
    output logic                   hsv_ready,
    input  hsv2rgb_pkg::hsv_word_t hsv,
    output logic                   rgb_valid,
    input  logic                   rgb_ready,
    output hsv2rgb_pkg::rgb_word_t rgb
);

    logic                      sec_valid;
    logic                      sec_ready;
    hsv2rgb_pkg::sector_word_t sec_data;
    logic                      scl_valid;
    logic                      scl_ready;
    hsv2rgb_pkg::scaled_word_t scl_data;

    hsv2rgb_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv_valid),
        .in_ready  (hsv_ready),
        .in_data   (hsv),
        .out_valid (sec_valid),
        .out_ready (sec_ready),
        .out_data  (sec_data)
    );

    hsv2rgb_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sec_valid),
        .in_ready  (sec_ready),
        .in_data   (sec_data),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_data  (scl_data)
    );

    hsv2rgb_route u_route (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_data   (scl_data),
        .out_valid (rgb_valid),
        .out_ready (rgb_ready),
        .out_data  (rgb)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_ready |-> rgb_valid && sec_valid && scl_valid)
    else $error("Input held off while the pipeline still has an empty stage.");

endmodule

// ===== tb/tb.sv =====
// Testbench for hsv_to_rgb_converter: random and directed pixel words with random idling
// on both channels, checked against a bit-exact fixed-point prediction held in a small class.
// Depends on hsv2rgb_pkg and the RTL of the converter only.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT = 400000;

    class rgb_tracker;

        hsv2rgb_pkg::rgb_word_t due_rgb[$];
        int unsigned            mismatches;

        function new();
            mismatches = 0;
        endfunction

        function hsv2rgb_pkg::rgb_word_t predict_rgb(hsv2rgb_pkg::hsv_word_t px);
            bit [63:0]                sat;
            bit [63:0]                val;
            bit [63:0]                top;
            bit [63:0]                one;
            bit [63:0]                den;
            bit [63:0]                h6;
            bit [63:0]                frac;
            bit [63:0]                pv;
            bit [63:0]                qv;
            bit [63:0]                tv;
            hsv2rgb_pkg::sector_t     sec;
            hsv2rgb_pkg::rgb_word_t   c;
            sat  = px.saturation;
            val  = px.brightness;
            top  = hsv2rgb_pkg::CH_MAX;
            one  = 64'd1 << hsv2rgb_pkg::HUE_BITS;
            den  = top << hsv2rgb_pkg::HUE_BITS;
            h6   = 64'(px.hue) * 6;
            sec  = hsv2rgb_pkg::sector_t'(h6[hsv2rgb_pkg::HUE_BITS+2:hsv2rgb_pkg::HUE_BITS]);
            frac = h6 & (one - 1);
            if (sat == 0)
            begin
                c.red   = val[hsv2rgb_pkg::CHANNEL_BITS-1:0];
                c.green = val[hsv2rgb_pkg::CHANNEL_BITS-1:0];
                c.blue  = val[hsv2rgb_pkg::CHANNEL_BITS-1:0];
                return c;
            end
            pv = (val * (top - sat)) / top;
            qv = (val * (den - sat * frac)) / den;
            tv = (val * (den - sat * (one - frac))) / den;
            case (sec)
                hsv2rgb_pkg::SECTOR_RED:    c = {val[7:0], tv[7:0], pv[7:0]};
                hsv2rgb_pkg::SECTOR_YELLOW: c = {qv[7:0], val[7:0], pv[7:0]};
                hsv2rgb_pkg::SECTOR_GREEN:  c = {pv[7:0], val[7:0], tv[7:0]};
                hsv2rgb_pkg::SECTOR_CYAN:   c = {pv[7:0], qv[7:0], val[7:0]};
                hsv2rgb_pkg::SECTOR_BLUE:   c = {tv[7:0], pv[7:0], val[7:0]};
                default:                    c = {val[7:0], pv[7:0], qv[7:0]};
            endcase
            return c;
        endfunction

        function void note_pixel(hsv2rgb_pkg::hsv_word_t px);
            due_rgb.push_back(predict_rgb(px));
        endfunction

        function void check_pixel(hsv2rgb_pkg::rgb_word_t got);
            hsv2rgb_pkg::rgb_word_t want;
            if (due_rgb.size() == 0)
            begin
                $error("rgb word %h arrived with none expected", got);
                mismatches++;
                return;
            end
            want = due_rgb.pop_front();
            if (got.red !== want.red)
            begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green)
            begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                mismatches++;
            end
        endfunction

        function int unsigned waiting();
            return due_rgb.size();
        endfunction

    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   hsv_valid = 1'b0;
    logic                   hsv_ready;
    hsv2rgb_pkg::hsv_word_t hsv = '0;
    logic                   rgb_valid;
    logic                   rgb_ready = 1'b0;
    hsv2rgb_pkg::rgb_word_t rgb;

    bit          calm = 1'b0;
    bit          hold_rgb = 1'b0;
    int unsigned cycle_count = 0;
    rgb_tracker  colour_check;

    hsv_to_rgb_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hsv_valid && hsv_ready)
                colour_check.note_pixel(hsv);
            if (rgb_valid && rgb_ready)
                colour_check.check_pixel(rgb);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_rgb)
            begin
                rgb_ready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_rgb = 1'b0;
            end
            else
                rgb_ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    function automatic logic [hsv2rgb_pkg::CHANNEL_BITS-1:0] edgy_channel();
        case ($urandom_range(5))
            0: return '0;
            1: return 8'd1;
            2: return 8'd254;
            3: return '1;
            default: return hsv2rgb_pkg::CHANNEL_BITS'($urandom);
        endcase
    endfunction

    function automatic hsv2rgb_pkg::hsv_word_t random_pixel();
        hsv2rgb_pkg::hsv_word_t px;
        int                     k;
        px = hsv2rgb_pkg::hsv_word_t'($urandom);
        case ($urandom_range(3))
            0: ;
            1:
            begin
                px.saturation = edgy_channel();
                px.brightness = edgy_channel();
            end
            default:
            begin
                k = $urandom_range(6);
                px.hue = hsv2rgb_pkg::HUE_BITS'((k * 65536 + 5) / 6 + $urandom_range(6) - 3);
                if ($urandom_range(1) == 0)
                    px.saturation = edgy_channel();
            end
        endcase
        return px;
    endfunction

    task automatic send_pixel(input hsv2rgb_pkg::hsv_word_t px);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 15)
            gap = $urandom_range(4, 1);
        if (gap != 0)
        begin
            hsv_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsv_valid <= 1'b1;
        hsv       <= px;
        @(posedge clk);
        while (!hsv_ready)
            @(posedge clk);
    endtask

    task automatic drain_rgb();
        hsv_valid <= 1'b0;
        @(posedge clk);
        while (colour_check.waiting() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        colour_check = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel({16'd0,     8'd255, 8'd255});
        send_pixel({16'd65535, 8'd255, 8'd255});
        send_pixel({16'd10922, 8'd255, 8'd255});
        send_pixel({16'd10923, 8'd255, 8'd255});
        send_pixel({16'd21845, 8'd255, 8'd255});
        send_pixel({16'd21846, 8'd255, 8'd200});
        send_pixel({16'd32767, 8'd255, 8'd255});
        send_pixel({16'd32768, 8'd255, 8'd255});
        send_pixel({16'd43690, 8'd128, 8'd255});
        send_pixel({16'd43691, 8'd255, 8'd255});
        send_pixel({16'd54613, 8'd255, 8'd255});
        send_pixel({16'd54614, 8'd255, 8'd255});
        send_pixel({16'd0,     8'd0,   8'd255});
        send_pixel({16'd30000, 8'd0,   8'd77});
        send_pixel({16'd65535, 8'd0,   8'd0});
        send_pixel({16'd12345, 8'd255, 8'd0});
        send_pixel({16'd40000, 8'd1,   8'd255});
        send_pixel({16'd50000, 8'd254, 8'd1});
        send_pixel({16'd5000,  8'd128, 8'd128});
        send_pixel({16'd60000, 8'd255, 8'd1});

        repeat (700) send_pixel(random_pixel());

        calm     = 1'b1;
        hold_rgb = 1'b1;
        repeat (40) send_pixel(random_pixel());
        calm = 1'b0;
        drain_rgb();

        calm = 1'b1;
        repeat (300) send_pixel(random_pixel());
        calm = 1'b0;
        repeat (940) send_pixel(random_pixel());

        drain_rgb();
        repeat (20) @(posedge clk);
        if (colour_check.mismatches == 0 && colour_check.waiting() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_sector.sv
rtl/hsv2rgb_scale.sv
rtl/hsv2rgb_route.sv
rtl/hsv_to_rgb_converter.sv
tb/tb.sv
